/* hdl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, always active
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/xxh64_pkg.sv */
package xxh64_pkg;

   // xxHash64 primes
   localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] P3 = 64'h165667B19E3779F9;
   localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FIN_INIT,
      ST_MERGE_SUM,
      ST_MERGE_LANE,
      ST_ADD_LEN,
      ST_TAIL,
      ST_PART4,
      ST_PART1,
      ST_AVAL
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LD_ACC,
      OP_LD_STRIPE,
      OP_LD_H,
      OP_LD_P32,
      OP_LD_P8,
      OP_MUL_LO,
      OP_MUL_MID,
      OP_MUL_END,
      OP_ADD_ACC,
      OP_ROTL,
      OP_XOR_H,
      OP_ST_ACC,
      OP_ST_H,
      OP_ADD_H,
      OP_H_INIT,
      OP_ADD_LEN,
      OP_XSHR,
      OP_SHR_P32,
      OP_SHR_P8,
      OP_CAPTURE
   } op_type;

   typedef enum logic [2:0] {
      K_ZERO,
      K_P1,
      K_P2,
      K_P3,
      K_P4,
      K_P5
   } kc_type;

   typedef struct packed {
      op_type      op;
      kc_type      kc;
      logic [5:0]  amt;
   } uop_type;

   typedef struct packed {
      uop_type     uop;
      logic [1:0]  lane;
      logic        accept;
   } cmd_type;

   typedef struct packed {
      logic        round_due;
      logic        big;
      logic [1:0]  wis;
      logic [2:0]  rem;
   } status_type;

   function automatic logic [63:0] kval(kc_type kc);
      logic [63:0] k;
      unique case (kc)
         K_P1:    k = P1;
         K_P2:    k = P2;
         K_P3:    k = P3;
         K_P4:    k = P4;
         K_P5:    k = P5;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] rotl(logic [63:0] v, logic [5:0] r);
      return (v << r) | (v >> (7'd64 - {1'b0, r}));
   endfunction

   function automatic uop_type mk(op_type op, kc_type kc, logic [5:0] amt);
      uop_type u;
      u.op  = op;
      u.kc  = kc;
      u.amt = amt;
      return u;
   endfunction

   // last step index of each phase
   function automatic logic [3:0] phase_last(state_type s);
      logic [3:0] n;
      unique case (s)
         ST_ROUND:      n = 4'd9;
         ST_MERGE_SUM:  n = 4'd2;
         ST_MERGE_LANE: n = 4'd12;
         ST_TAIL:       n = 4'd13;
         ST_PART4:      n = 4'd10;
         ST_PART1:      n = 4'd10;
         ST_AVAL:       n = 4'd9;
         default:       n = 4'd0;
      endcase
      return n;
   endfunction

   // micro-program: datapath operation for a phase step
   function automatic uop_type uop_at(state_type s, logic [3:0] step, logic [1:0] lane);
      uop_type u;
      logic [5:0] mr;
      u = mk(OP_NOP, K_ZERO, 6'd0);
      unique case (lane)
         2'd0:    mr = 6'd1;
         2'd1:    mr = 6'd7;
         2'd2:    mr = 6'd12;
         default: mr = 6'd18;
      endcase
      unique case (s)
         ST_ROUND: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_STRIPE, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_MUL_LO, K_P2, 6'd0);
               4'd2:    u = mk(OP_MUL_MID, K_P2, 6'd0);
               4'd3:    u = mk(OP_MUL_END, K_P2, 6'd0);
               4'd4:    u = mk(OP_ADD_ACC, K_ZERO, 6'd0);
               4'd5:    u = mk(OP_ROTL, K_ZERO, 6'd31);
               4'd6:    u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd7:    u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd8:    u = mk(OP_MUL_END, K_P1, 6'd0);
               default: u = mk(OP_ST_ACC, K_ZERO, 6'd0);
            endcase
         end
         ST_FIN_INIT: u = mk(OP_H_INIT, K_ZERO, 6'd0);
         ST_MERGE_SUM: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_ACC, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_ROTL, K_ZERO, mr);
               default: u = mk(OP_ADD_H, K_ZERO, 6'd0);
            endcase
         end
         ST_MERGE_LANE: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_ACC, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_MUL_LO, K_P2, 6'd0);
               4'd2:    u = mk(OP_MUL_MID, K_P2, 6'd0);
               4'd3:    u = mk(OP_MUL_END, K_P2, 6'd0);
               4'd4:    u = mk(OP_ROTL, K_ZERO, 6'd31);
               4'd5:    u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd6:    u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd7:    u = mk(OP_MUL_END, K_P1, 6'd0);
               4'd8:    u = mk(OP_XOR_H, K_ZERO, 6'd0);
               4'd9:    u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd10:   u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd11:   u = mk(OP_MUL_END, K_P1, 6'd0);
               default: u = mk(OP_ST_H, K_P4, 6'd0);
            endcase
         end
         ST_ADD_LEN: u = mk(OP_ADD_LEN, K_ZERO, 6'd0);
         ST_TAIL: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_STRIPE, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_MUL_LO, K_P2, 6'd0);
               4'd2:    u = mk(OP_MUL_MID, K_P2, 6'd0);
               4'd3:    u = mk(OP_MUL_END, K_P2, 6'd0);
               4'd4:    u = mk(OP_ROTL, K_ZERO, 6'd31);
               4'd5:    u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd6:    u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd7:    u = mk(OP_MUL_END, K_P1, 6'd0);
               4'd8:    u = mk(OP_XOR_H, K_ZERO, 6'd0);
               4'd9:    u = mk(OP_ROTL, K_ZERO, 6'd27);
               4'd10:   u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd11:   u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd12:   u = mk(OP_MUL_END, K_P1, 6'd0);
               default: u = mk(OP_ST_H, K_P4, 6'd0);
            endcase
         end
         ST_PART4: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_P32, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd2:    u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd3:    u = mk(OP_MUL_END, K_P1, 6'd0);
               4'd4:    u = mk(OP_XOR_H, K_ZERO, 6'd0);
               4'd5:    u = mk(OP_ROTL, K_ZERO, 6'd23);
               4'd6:    u = mk(OP_MUL_LO, K_P2, 6'd0);
               4'd7:    u = mk(OP_MUL_MID, K_P2, 6'd0);
               4'd8:    u = mk(OP_MUL_END, K_P2, 6'd0);
               4'd9:    u = mk(OP_ST_H, K_P3, 6'd0);
               default: u = mk(OP_SHR_P32, K_ZERO, 6'd0);
            endcase
         end
         ST_PART1: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_P8, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_MUL_LO, K_P5, 6'd0);
               4'd2:    u = mk(OP_MUL_MID, K_P5, 6'd0);
               4'd3:    u = mk(OP_MUL_END, K_P5, 6'd0);
               4'd4:    u = mk(OP_XOR_H, K_ZERO, 6'd0);
               4'd5:    u = mk(OP_ROTL, K_ZERO, 6'd11);
               4'd6:    u = mk(OP_MUL_LO, K_P1, 6'd0);
               4'd7:    u = mk(OP_MUL_MID, K_P1, 6'd0);
               4'd8:    u = mk(OP_MUL_END, K_P1, 6'd0);
               4'd9:    u = mk(OP_ST_H, K_ZERO, 6'd0);
               default: u = mk(OP_SHR_P8, K_ZERO, 6'd0);
            endcase
         end
         ST_AVAL: begin
            unique case (step)
               4'd0:    u = mk(OP_LD_H, K_ZERO, 6'd0);
               4'd1:    u = mk(OP_XSHR, K_ZERO, 6'd33);
               4'd2:    u = mk(OP_MUL_LO, K_P2, 6'd0);
               4'd3:    u = mk(OP_MUL_MID, K_P2, 6'd0);
               4'd4:    u = mk(OP_MUL_END, K_P2, 6'd0);
               4'd5:    u = mk(OP_XSHR, K_ZERO, 6'd29);
               4'd6:    u = mk(OP_MUL_LO, K_P3, 6'd0);
               4'd7:    u = mk(OP_MUL_MID, K_P3, 6'd0);
               4'd8:    u = mk(OP_MUL_END, K_P3, 6'd0);
               default: u = mk(OP_CAPTURE, K_ZERO, 6'd0);
            endcase
         end
         default: u = mk(OP_NOP, K_ZERO, 6'd0);
      endcase
      return u;
   endfunction

endpackage

/* hdl/xxh64_ctrl.sv */
module xxh64_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_word,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_we,
   input  xxh64_pkg::status_type  status,
   output xxh64_pkg::cmd_type     cmd
);

   xxh64_pkg::state_type state_ff, state_in;
   logic [3:0]           step_ff, step_in;
   logic [1:0]           lane_ff, lane_in;
   logic                 fin_ff, fin_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 phase_end;
   logic                 out_wait;
   xxh64_pkg::state_type part_state;

   assign req_ready = (state_ff == xxh64_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign phase_end = (step_ff == xxh64_pkg::phase_last(state_ff));
   // digest capture waits while the previous digest is still unaccepted
   assign out_wait  = (state_ff == xxh64_pkg::ST_AVAL) && phase_end &&
                      rsp_valid_ff && !rsp_ready;

   // pick the tail-byte phase from the remaining byte count
   always_comb begin
      if (status.rem >= 3'd4) begin
         part_state = xxh64_pkg::ST_PART4;
      end else if (status.rem != 3'd0) begin
         part_state = xxh64_pkg::ST_PART1;
      end else begin
         part_state = xxh64_pkg::ST_AVAL;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      step_in      = phase_end ? 4'd0 : step_ff + 4'd1;
      lane_in      = lane_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         xxh64_pkg::ST_IDLE: begin
            step_in = 4'd0;
            lane_in = 2'd0;
            if (accept) begin
               fin_in = req_last_word;
               if (status.round_due) begin
                  state_in = xxh64_pkg::ST_ROUND;
               end else if (req_last_word) begin
                  state_in = xxh64_pkg::ST_FIN_INIT;
               end
            end
         end
         xxh64_pkg::ST_ROUND: begin
            if (phase_end) begin
               lane_in = lane_ff + 2'd1;
               if (lane_ff == 2'd3) begin
                  state_in = fin_ff ? xxh64_pkg::ST_FIN_INIT : xxh64_pkg::ST_IDLE;
               end
            end
         end
         xxh64_pkg::ST_FIN_INIT: begin
            lane_in  = 2'd0;
            state_in = status.big ? xxh64_pkg::ST_MERGE_SUM : xxh64_pkg::ST_ADD_LEN;
         end
         xxh64_pkg::ST_MERGE_SUM: begin
            if (phase_end) begin
               lane_in = lane_ff + 2'd1;
               if (lane_ff == 2'd3) begin
                  state_in = xxh64_pkg::ST_MERGE_LANE;
               end
            end
         end
         xxh64_pkg::ST_MERGE_LANE: begin
            if (phase_end) begin
               lane_in = lane_ff + 2'd1;
               if (lane_ff == 2'd3) begin
                  state_in = xxh64_pkg::ST_ADD_LEN;
               end
            end
         end
         xxh64_pkg::ST_ADD_LEN: begin
            lane_in  = 2'd0;
            state_in = (status.wis != 2'd0) ? xxh64_pkg::ST_TAIL : part_state;
         end
         xxh64_pkg::ST_TAIL: begin
            if (phase_end) begin
               lane_in = lane_ff + 2'd1;
               if (lane_ff == status.wis - 2'd1) begin
                  state_in = part_state;
               end
            end
         end
         xxh64_pkg::ST_PART4: begin
            if (phase_end) begin
               // count drops by four at this edge
               state_in = (status.rem != 3'd4) ? xxh64_pkg::ST_PART1 : xxh64_pkg::ST_AVAL;
            end
         end
         xxh64_pkg::ST_PART1: begin
            if (phase_end && status.rem == 3'd1) begin
               state_in = xxh64_pkg::ST_AVAL;
            end
         end
         xxh64_pkg::ST_AVAL: begin
            if (out_wait) begin
               step_in = step_ff;
            end else if (phase_end) begin
               state_in     = xxh64_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               fin_in       = 1'b0;
            end
         end
         default: state_in = xxh64_pkg::ST_IDLE;
      endcase
      // a seed write abandons the message
      if (csr_we) begin
         state_in = xxh64_pkg::ST_IDLE;
         fin_in   = 1'b0;
      end
   end

   // datapath command
   always_comb begin
      cmd.uop    = out_wait ?
                   xxh64_pkg::mk(xxh64_pkg::OP_NOP, xxh64_pkg::K_ZERO, 6'd0) :
                   xxh64_pkg::uop_at(state_ff, step_ff, lane_ff);
      cmd.lane   = lane_ff;
      cmd.accept = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xxh64_pkg::ST_IDLE;
         step_ff      <= 4'd0;
         lane_ff      <= 2'd0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         lane_ff      <= lane_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/xxh64_dpath.sv */
module xxh64_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [63:0]            csr_wdata,
   input  logic [63:0]            req_data_word,
   input  logic [3:0]             req_byte_count,
   input  logic                   req_last_word,
   input  xxh64_pkg::cmd_type     cmd,
   output xxh64_pkg::status_type  status,
   output logic [63:0]            rsp_digest
);

   logic [63:0] seed_ff, seed_in;
   logic [63:0] acc_ff [4];
   logic [63:0] acc_in [4];
   logic [63:0] stripe_ff [4];
   logic [1:0]  wis_ff, wis_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] part_ff, part_in;
   logic [2:0]  rem_ff, rem_in;
   logic [63:0] digest_ff, digest_in;
   logic [63:0] k;
   logic [63:0] seed_new;
   logic [63:0] mul_lo;
   logic [31:0] mul_cross;
   logic        full_word;
   logic        restart;

   assign k         = xxh64_pkg::kval(cmd.uop.kc);
   assign full_word = !req_last_word || (req_byte_count >= 4'd8);
   assign restart   = csr_we || (cmd.uop.op == xxh64_pkg::OP_CAPTURE);
   assign seed_new  = csr_we ? csr_wdata : seed_ff;

   assign status.round_due = full_word && (wis_ff == 2'd3);
   assign status.big       = (total_ff[63:5] != '0);
   assign status.wis       = wis_ff;
   assign status.rem       = rem_ff;
   assign rsp_digest       = digest_ff;

   // 64x64 low product built from three 32x32 partials
   always_comb begin
      mul_lo    = x_ff[31:0] * k[31:0];
      mul_cross = (cmd.uop.op == xxh64_pkg::OP_MUL_MID) ?
                  32'(x_ff[31:0] * k[63:32]) : 32'(x_ff[63:32] * k[31:0]);
   end

   // operation decode
   always_comb begin
      seed_in   = seed_new;
      acc_in    = acc_ff;
      wis_in    = wis_ff;
      total_in  = total_ff;
      h_in      = h_ff;
      x_in      = x_ff;
      prod_in   = prod_ff;
      part_in   = part_ff;
      rem_in    = rem_ff;
      digest_in = digest_ff;
      unique case (cmd.uop.op)
         xxh64_pkg::OP_LD_ACC:    x_in = acc_ff[cmd.lane];
         xxh64_pkg::OP_LD_STRIPE: x_in = stripe_ff[cmd.lane];
         xxh64_pkg::OP_LD_H:      x_in = h_ff;
         xxh64_pkg::OP_LD_P32:    x_in = {32'd0, part_ff[31:0]};
         xxh64_pkg::OP_LD_P8:     x_in = {56'd0, part_ff[7:0]};
         xxh64_pkg::OP_MUL_LO:    prod_in = mul_lo;
         xxh64_pkg::OP_MUL_MID:   prod_in = prod_ff + {mul_cross, 32'd0};
         xxh64_pkg::OP_MUL_END:   x_in = prod_ff + {mul_cross, 32'd0};
         xxh64_pkg::OP_ADD_ACC:   x_in = acc_ff[cmd.lane] + x_ff;
         xxh64_pkg::OP_ROTL:      x_in = xxh64_pkg::rotl(x_ff, cmd.uop.amt);
         xxh64_pkg::OP_XOR_H:     x_in = h_ff ^ x_ff;
         xxh64_pkg::OP_ST_ACC:    acc_in[cmd.lane] = x_ff;
         xxh64_pkg::OP_ST_H:      h_in = x_ff + k;
         xxh64_pkg::OP_ADD_H:     h_in = h_ff + x_ff;
         xxh64_pkg::OP_H_INIT:    h_in = status.big ? 64'd0 : seed_ff + xxh64_pkg::P5;
         xxh64_pkg::OP_ADD_LEN:   h_in = h_ff + total_ff;
         xxh64_pkg::OP_XSHR:      x_in = x_ff ^ (x_ff >> cmd.uop.amt);
         xxh64_pkg::OP_SHR_P32: begin
            part_in = {32'd0, part_ff[63:32]};
            rem_in  = rem_ff - 3'd4;
         end
         xxh64_pkg::OP_SHR_P8: begin
            part_in = {8'd0, part_ff[63:8]};
            rem_in  = rem_ff - 3'd1;
         end
         xxh64_pkg::OP_CAPTURE:   digest_in = x_ff ^ (x_ff >> 32);
         default: ;
      endcase
      // incoming word
      if (cmd.accept) begin
         if (full_word) begin
            wis_in   = wis_ff + 2'd1;
            total_in = total_ff + 64'd8;
            rem_in   = 3'd0;
         end else begin
            total_in = total_ff + {60'd0, req_byte_count};
            part_in  = req_data_word;
            rem_in   = req_byte_count[2:0];
         end
      end
      // fresh message from the seed
      if (restart) begin
         acc_in[0] = seed_new + xxh64_pkg::P1 + xxh64_pkg::P2;
         acc_in[1] = seed_new + xxh64_pkg::P2;
         acc_in[2] = seed_new;
         acc_in[3] = seed_new - xxh64_pkg::P1;
         wis_in    = 2'd0;
         total_in  = 64'd0;
      end
   end

   // control-like state
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 64'd0;
         acc_ff[0] <= xxh64_pkg::P1 + xxh64_pkg::P2;
         acc_ff[1] <= xxh64_pkg::P2;
         acc_ff[2] <= 64'd0;
         acc_ff[3] <= 64'd0 - xxh64_pkg::P1;
         wis_ff   <= 2'd0;
         total_ff <= 64'd0;
         rem_ff   <= 3'd0;
      end else begin
         seed_ff  <= seed_in;
         acc_ff   <= acc_in;
         wis_ff   <= wis_in;
         total_ff <= total_in;
         rem_ff   <= rem_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      h_ff      <= h_in;
      x_ff      <= x_in;
      prod_ff   <= prod_in;
      part_ff   <= part_in;
      digest_ff <= digest_in;
      if (cmd.accept && full_word) begin
         stripe_ff[wis_ff] <= req_data_word;
      end
   end

endmodule

/* hdl/xxhash64_stream_digest_top.sv */
// Word that does not close a stripe: it is taken, and the next one may follow at once.
// Word that closes a stripe: round updates follow (4 lanes x 10 steps).
// Last word: finalization steps run to the digest, each 64-bit product built
// from 32x32 partials; new requests stream in while a digest waits, and only
// the final capture step holds for it.
// Synchronous active-high reset: seed 0, accumulators from seed, idle.
module xxhash64_stream_digest_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);

   xxh64_pkg::cmd_type    cmd;
   xxh64_pkg::status_type status;

   // sequencer
   xxh64_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_word (req_last_word),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .csr_we        (csr_we),
      .status        (status),
      .cmd           (cmd)
   );

   // hash datapath
   xxh64_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .cmd            (cmd),
      .status         (status),
      .rsp_digest     (rsp_digest)
   );

endmodule

/* hdl/xxh64_checker.sv */
`include "assert_macros.svh"

module xxh64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_digest
);

   // nothing pending right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

   // stalled digest holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest))

   // final word starts a multi-cycle finalization unless a seed write comes with it
   `ASSERT_NEXT(a_fin_busy, clock, reset, req_valid && req_ready && req_last_word, !req_ready)

endmodule

bind xxhash64_stream_digest_top xxh64_checker u_xxh64_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_word (req_last_word),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_digest    (rsp_digest)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_digest;
   logic        csr_we = 1'b0;
   logic [63:0] csr_wdata = '0;

   // predictor state
   logic [63:0] hash_seed;
   logic [63:0] lane_acc [4];
   logic [63:0] pending_words [4];
   int unsigned pending_count;
   logic [63:0] msg_length;

   logic [63:0] digest_queue [$];
   int          error_count = 0;
   bit          stall_enable = 1'b1;

   xxhash64_stream_digest_top uut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] rot_left(logic [63:0] x, int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] lane_round(logic [63:0] acc, logic [63:0] w);
      return rot_left(acc + w * xxh64_pkg::P2, 31) * xxh64_pkg::P1;
   endfunction

   function automatic void restart_message();
      lane_acc[0] = hash_seed + xxh64_pkg::P1 + xxh64_pkg::P2;
      lane_acc[1] = hash_seed + xxh64_pkg::P2;
      lane_acc[2] = hash_seed;
      lane_acc[3] = hash_seed - xxh64_pkg::P1;
      pending_count = 0;
      msg_length = '0;
   endfunction

   function automatic void absorb_word(logic [63:0] w);
      pending_words[pending_count] = w;
      pending_count++;
      msg_length += 8;
      if (pending_count == 4) begin
         for (int i = 0; i < 4; i++) lane_acc[i] = lane_round(lane_acc[i], pending_words[i]);
         pending_count = 0;
      end
   endfunction

   function automatic logic [63:0] finalize_digest(logic [63:0] part, int n);
      logic [63:0] h;
      if (msg_length >= 32) begin
         h = rot_left(lane_acc[0], 1) + rot_left(lane_acc[1], 7) +
             rot_left(lane_acc[2], 12) + rot_left(lane_acc[3], 18);
         for (int i = 0; i < 4; i++)
            h = (h ^ lane_round('0, lane_acc[i])) * xxh64_pkg::P1 + xxh64_pkg::P4;
      end else begin
         h = hash_seed + xxh64_pkg::P5;
      end
      h += msg_length;
      for (int i = 0; i < pending_count; i++)
         h = rot_left(h ^ lane_round('0, pending_words[i]), 27) * xxh64_pkg::P1 +
             xxh64_pkg::P4;
      if (n >= 4) begin
         h = rot_left(h ^ ({32'd0, part[31:0]} * xxh64_pkg::P1), 23) * xxh64_pkg::P2 +
             xxh64_pkg::P3;
         part = part >> 32;
         n -= 4;
      end
      while (n > 0) begin
         h = rot_left(h ^ ({56'd0, part[7:0]} * xxh64_pkg::P5), 11) * xxh64_pkg::P1;
         part = part >> 8;
         n--;
      end
      h ^= h >> 33;
      h *= xxh64_pkg::P2;
      h ^= h >> 29;
      h *= xxh64_pkg::P3;
      h ^= h >> 32;
      return h;
   endfunction

   // expected digest for one request, if any
   function automatic void predict_word(logic [63:0] w, logic [3:0] cnt, logic last);
      int n;
      if (!last) begin
         absorb_word(w);
         return;
      end
      n = (cnt > 8) ? 8 : cnt;
      if (n == 8) begin
         absorb_word(w);
         digest_queue.push_back(finalize_digest('0, 0));
      end else begin
         msg_length += n;
         digest_queue.push_back(finalize_digest(w, n));
      end
      restart_message();
   endfunction

   // send one request with random idle before it
   task automatic send_word(logic [63:0] w, logic [3:0] cnt, logic last);
      while (stall_enable && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_word <= w;
      req_byte_count <= cnt;
      req_last_word <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(w, cnt, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_seed(logic [63:0] s);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= s;
      @(posedge clock);
      csr_we <= 1'b0;
      hash_seed = s;
      restart_message();
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_message(int words, int tail);
      for (int i = 0; i < words; i++) send_word(rand64(), 4'd8, 1'b0);
      send_word(rand64(), tail[3:0], 1'b1);
   endtask

   // directed: empty message, field extremes, tail sizes, oversized counts
   task automatic test_directed();
      send_word('0, 4'd0, 1'b1);
      send_word('1, 4'd8, 1'b1);
      send_word('1, 4'd15, 1'b1);
      for (int t = 1; t < 8; t++) send_word(64'h0123456789ABCDEF, t[3:0], 1'b1);
      // short middle word is taken whole
      send_word(64'hFFFF_0000_FFFF_0000, 4'd3, 1'b0);
      send_word(64'h5555_AAAA_5555_AAAA, 4'd0, 1'b1);
      send_message(3, 8);
      send_message(4, 0);
      send_message(7, 12);
   endtask

   // seed write in the middle of a message abandons it
   task automatic test_seed_abort();
      send_word(rand64(), 4'd8, 1'b0);
      send_word(rand64(), 4'd8, 1'b0);
      write_seed(64'h0000_0000_0000_0001);
      send_message(5, 3);
   endtask

   task automatic test_random(int count);
      int sent = 0;
      int len;
      while (sent < count) begin
         len = ($urandom_range(9) == 0) ? int'($urandom_range(40)) : int'($urandom_range(9));
         if ($urandom_range(19) == 0) begin
            for (int i = 0; i < len; i++)
               send_word(rand64(), 4'($urandom_range(15)), 1'b0);
            send_word(rand64(), 4'($urandom_range(15)), 1'b1);
         end else begin
            send_message(len, int'($urandom_range(8)));
         end
         sent += len + 1;
      end
   endtask

   // result stall and check
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !stall_enable || ($urandom_range(99) >= 23);
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $error("digest: unexpected result %h", rsp_digest);
               error_count++;
            end else begin
               logic [63:0] want;
               want = digest_queue.pop_front();
               if (rsp_digest !== want) begin
                  $error("digest: expected %h actual %h", want, rsp_digest);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      hash_seed = '0;
      restart_message();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_seed_abort();
      write_seed('1);
      test_random(300);
      write_seed(64'h0);
      stall_enable = 1'b0;
      test_random(250);
      stall_enable = 1'b1;
      write_seed({$urandom, $urandom});
      test_random(450);
      write_seed(64'h8000_0000_0000_0000);
      test_random(450);
      drain();
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
